>>> rtl/lbm_pkg.sv
`timescale 1ns / 1ps
package lbm_pkg;

	localparam int STRIP_LENGTH_DEF = 60;

	localparam logic [10:0] FULL_SCALE = 11'd1023;

	localparam logic [2:0] REG_BAR_BLUE   = 3'd0;
	localparam logic [2:0] REG_BAR_GREEN  = 3'd1;
	localparam logic [2:0] REG_BAR_YELLOW = 3'd2;
	localparam logic [2:0] REG_MIR_BLUE   = 3'd3;
	localparam logic [2:0] REG_MIR_GREEN  = 3'd4;
	localparam logic [2:0] REG_MIR_YELLOW = 3'd5;

	localparam logic [6:0] RST_BAR_BLUE   = 7'd6;
	localparam logic [6:0] RST_BAR_GREEN  = 7'd36;
	localparam logic [6:0] RST_BAR_YELLOW = 7'd51;
	localparam logic [6:0] RST_MIR_BLUE   = 7'd3;
	localparam logic [6:0] RST_MIR_GREEN  = 7'd18;
	localparam logic [6:0] RST_MIR_YELLOW = 7'd26;

	typedef struct packed {
		logic [9:0] level_sample;
		logic       mirror_mode;
	} item_t;

	typedef struct packed {
		logic [5:0] pixel_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last_pixel;
	} result_t;

	typedef struct packed {
		logic [6:0] bar_blue_end;
		logic [6:0] bar_green_end;
		logic [6:0] bar_yellow_end;
		logic [6:0] mirror_blue_end;
		logic [6:0] mirror_green_end;
		logic [6:0] mirror_yellow_end;
	} limits_t;

	typedef struct packed {
		logic [6:0] count;
		logic       mirror;
	} scaled_t;

	typedef struct packed {
		logic       valid;
		logic [5:0] idx;
		logic [6:0] count;
		logic       mirror;
		logic       last;
	} pix_t;

endpackage

>>> rtl/led_bar_level_meter.sv
`timescale 1ns / 1ps
// When idle, a start transfer passes the scaler stages, the pixel sequencer and the
// colour stages before its first pixel is strobed. The pixel sequencer sets one pixel
// per cycle in a frame; up to two samples queue behind it and follow with no gap.
// The receiver cannot stall: each pixel is shown for one cycle under result_valid.
// Reset (arst_n low) empties the pipeline and loads the default band limits.
module led_bar_level_meter import lbm_pkg::*; #(
	parameter int STRIP_LENGTH = STRIP_LENGTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  item_t      item,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [6:0] cfg_data,
	output logic       result_valid,
	output result_t    result
);

	limits_t limits_q;
	logic    scaled_valid;
	scaled_t scaled;
	logic    take;
	pix_t    pix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.bar_blue_end      <= RST_BAR_BLUE;
			limits_q.bar_green_end     <= RST_BAR_GREEN;
			limits_q.bar_yellow_end    <= RST_BAR_YELLOW;
			limits_q.mirror_blue_end   <= RST_MIR_BLUE;
			limits_q.mirror_green_end  <= RST_MIR_GREEN;
			limits_q.mirror_yellow_end <= RST_MIR_YELLOW;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BAR_BLUE:   limits_q.bar_blue_end      <= cfg_data;
				REG_BAR_GREEN:  limits_q.bar_green_end     <= cfg_data;
				REG_BAR_YELLOW: limits_q.bar_yellow_end    <= cfg_data;
				REG_MIR_BLUE:   limits_q.mirror_blue_end   <= cfg_data;
				REG_MIR_GREEN:  limits_q.mirror_green_end  <= cfg_data;
				REG_MIR_YELLOW: limits_q.mirror_yellow_end <= cfg_data;
				default: ;
			endcase
		end
	end

	lbm_scale #(.STRIP_LENGTH(STRIP_LENGTH)) u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.item         (item),
		.busy         (busy),
		.take         (take),
		.scaled_valid (scaled_valid),
		.scaled       (scaled)
	);

	lbm_seq #(.STRIP_LENGTH(STRIP_LENGTH)) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.scaled_valid (scaled_valid),
		.scaled       (scaled),
		.take         (take),
		.pix          (pix)
	);

	lbm_colour #(.STRIP_LENGTH(STRIP_LENGTH)) u_colour (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix          (pix),
		.limits       (limits_q),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

>>> rtl/lbm_scale.sv
`timescale 1ns / 1ps
module lbm_scale import lbm_pkg::*; #(
	parameter int STRIP_LENGTH = STRIP_LENGTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  item_t   item,
	output logic    busy,
	input  logic    take,
	output logic    scaled_valid,
	output scaled_t scaled
);

	localparam logic [15:0] N16 = 16'(STRIP_LENGTH);

	logic        v_s1, v_s2;
	logic [15:0] prod_s1;
	logic        mirror_s1;
	scaled_t     scaled_s2;
	logic        adv1, adv2;
	logic [5:0]  q0;
	logic [10:0] rem;
	logic [6:0]  count;

	assign adv2 = !v_s2 || take;
	assign adv1 = !v_s1 || adv2;
	assign busy = !adv1;

	// x / 1023: quotient estimate x >> 10, remainder stays below 2 * 1023
	assign q0    = prod_s1[15:10];
	assign rem   = {1'b0, prod_s1[9:0]} + 11'(q0);
	assign count = 7'(q0) + ((rem >= FULL_SCALE) ? 7'd1 : 7'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= start;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			prod_s1   <= 16'(item.level_sample) * N16;
			mirror_s1 <= item.mirror_mode;
		end
		if (adv2) begin
			scaled_s2.count  <= count;
			scaled_s2.mirror <= mirror_s1;
		end
	end

	assign scaled_valid = v_s2;
	assign scaled       = scaled_s2;

endmodule

>>> rtl/lbm_seq.sv
`timescale 1ns / 1ps
module lbm_seq import lbm_pkg::*; #(
	parameter int STRIP_LENGTH = STRIP_LENGTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    scaled_valid,
	input  scaled_t scaled,
	output logic    take,
	output pix_t    pix
);

	localparam logic [5:0] LAST = 6'(STRIP_LENGTH - 1);

	logic       active_q;
	logic [5:0] idx_q;
	logic [6:0] count_q;
	logic       mirror_q;

	assign take = !active_q || (idx_q == LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (take) begin
			active_q <= scaled_valid;
			idx_q    <= '0;
		end else begin
			idx_q <= idx_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			count_q  <= scaled.count;
			mirror_q <= scaled.mirror;
		end
	end

	assign pix.valid  = active_q;
	assign pix.idx    = idx_q;
	assign pix.count  = count_q;
	assign pix.mirror = mirror_q;
	assign pix.last   = (idx_q == LAST);

endmodule

>>> rtl/lbm_colour.sv
`timescale 1ns / 1ps
module lbm_colour import lbm_pkg::*; #(
	parameter int STRIP_LENGTH = STRIP_LENGTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  pix_t    pix,
	input  limits_t limits,
	output logic    result_valid,
	output result_t result
);

	localparam logic [5:0] LAST = 6'(STRIP_LENGTH - 1);

	localparam logic [2:0] BAND_OFF    = 3'd0;
	localparam logic [2:0] BAND_BLUE   = 3'd1;
	localparam logic [2:0] BAND_GREEN  = 3'd2;
	localparam logic [2:0] BAND_YELLOW = 3'd3;
	localparam logic [2:0] BAND_RED    = 3'd4;

	logic       v_s1, v_s2, v_s3;
	logic [5:0] idx_s1, idx_s2;
	logic       lit_s1;
	logic [5:0] pos_s1;
	logic       mirror_s1;
	logic       blue_hi_s1, blue_hi_s2;
	logic       last_s1, last_s2;
	logic [2:0] band_s2;
	result_t    result_s3;

	logic [5:0] half, far_d, pos;
	logic       lit, blue_hi;
	logic [6:0] b_end, g_end, y_end;
	logic [2:0] band;
	logic [7:0] r, g, b;

	assign half  = pix.count[6:1];
	assign far_d = LAST - pix.idx;

	always_comb begin
		lit     = 1'b0;
		pos     = pix.idx;
		blue_hi = 1'b0;
		if (!pix.mirror) begin
			lit = {1'b0, pix.idx} < pix.count;
		end else if (pix.idx < half) begin
			lit     = 1'b1;
			blue_hi = 1'b1;
		end else if (far_d < half) begin
			lit = 1'b1;
			pos = far_d;
		end
	end

	assign b_end = mirror_s1 ? limits.mirror_blue_end   : limits.bar_blue_end;
	assign g_end = mirror_s1 ? limits.mirror_green_end  : limits.bar_green_end;
	assign y_end = mirror_s1 ? limits.mirror_yellow_end : limits.bar_yellow_end;

	always_comb begin
		if (!lit_s1)                   band = BAND_OFF;
		else if ({1'b0, pos_s1} < b_end) band = BAND_BLUE;
		else if ({1'b0, pos_s1} < g_end) band = BAND_GREEN;
		else if ({1'b0, pos_s1} < y_end) band = BAND_YELLOW;
		else                           band = BAND_RED;
	end

	always_comb begin
		case (band_s2)
			BAND_BLUE: begin
				r = 8'd0;
				g = 8'd25;
				b = blue_hi_s2 ? 8'd255 : 8'd225;
			end
			BAND_GREEN: begin
				r = 8'd0;
				g = 8'd255;
				b = 8'd25;
			end
			BAND_YELLOW: begin
				r = 8'd120;
				g = 8'd225;
				b = 8'd0;
			end
			BAND_RED: begin
				r = 8'd255;
				g = 8'd0;
				b = 8'd0;
			end
			default: begin
				r = 8'd0;
				g = 8'd0;
				b = 8'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= pix.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1     <= pix.idx;
		lit_s1     <= lit;
		pos_s1     <= pos;
		mirror_s1  <= pix.mirror;
		blue_hi_s1 <= blue_hi;
		last_s1    <= pix.last;

		idx_s2     <= idx_s1;
		band_s2    <= band;
		blue_hi_s2 <= blue_hi_s1;
		last_s2    <= last_s1;

		result_s3.pixel_index <= idx_s2;
		result_s3.red         <= r;
		result_s3.green       <= g;
		result_s3.blue        <= b;
		result_s3.last_pixel  <= last_s2;
	end

	assign result_valid = v_s3;
	assign result       = result_s3;

endmodule

>>> rtl/lbm_checker.sv
`timescale 1ns / 1ps
module lbm_checker import lbm_pkg::*; #(
	parameter int STRIP_LENGTH = STRIP_LENGTH_DEF
) (
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input result_t result
);

	localparam logic [5:0] LAST = 6'(STRIP_LENGTH - 1);

	// a frame goes out without gaps
	a_frame_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_pixel |=> result_valid)
		else $error("gap inside a frame");

	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_pixel |=>
			result.pixel_index == $past(result.pixel_index) + 6'd1)
		else $error("pixel index did not advance by one");

	a_last_marks_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.last_pixel == (result.pixel_index == LAST)))
		else $error("last pixel mark misplaced");

	a_legal_colour: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
			(result.red == 8'd0 && result.green == 8'd0 && result.blue == 8'd0) ||
			(result.red == 8'd0 && result.green == 8'd25 && result.blue == 8'd255) ||
			(result.red == 8'd0 && result.green == 8'd25 && result.blue == 8'd225) ||
			(result.red == 8'd0 && result.green == 8'd255 && result.blue == 8'd25) ||
			(result.red == 8'd120 && result.green == 8'd225 && result.blue == 8'd0) ||
			(result.red == 8'd255 && result.green == 8'd0 && result.blue == 8'd0))
		else $error("colour outside the palette");

endmodule

bind led_bar_level_meter lbm_checker #(.STRIP_LENGTH(STRIP_LENGTH)) u_lbm_checker (.*);
